/* rtl/core/lpc_pkg.sv */
// ============================================================================
// lpc_pkg
// Shared types, step codes and the control store of the plus-cross search.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

  // Field widths of the item ports
  localparam int DIM_W  = 5;
  localparam int ARM_W  = 3;
  localparam int POS_W  = 4;
  localparam logic [ARM_W-1:0] ARM_MAX = 3'd7;

  // Sequencer step codes
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_ROW   = 4'd0;  // issue read of the scan row
  localparam step_t S_LATCH = 4'd1;  // capture the scan row
  localparam step_t S_CELL  = 4'd2;  // test center cell, open arm walk
  localparam step_t S_RD    = 4'd3;  // read rows above and below at distance k
  localparam step_t S_CHK   = 4'd4;  // test the four arm cells at distance k
  localparam step_t S_CMP   = 4'd5;  // fold arm into the running best
  localparam step_t S_NEXTC = 4'd6;  // advance column
  localparam step_t S_NEXTR = 4'd7;  // advance row
  localparam step_t S_DONE  = 4'd8;  // emit result, halt

  // Jump conditions
  localparam int COND_W = 3;
  typedef logic [COND_W-1:0] cond_t;

  localparam cond_t JC_NONE     = 3'd0;  // fall through
  localparam cond_t JC_CELL_CLR = 3'd1;  // center cell is clear
  localparam cond_t JC_ARM_GO   = 3'd2;  // all four arm cells set, arm below max
  localparam cond_t JC_COL_MORE = 3'd3;  // columns remain in this row
  localparam cond_t JC_ROW_MORE = 3'd4;  // rows remain in the grid

  // One control word
  typedef struct packed {
    logic  rd_row;
    logic  ld_row;
    logic  begin_cell;
    logic  chk_arm;
    logic  cmp_best;
    logic  adv_col;
    logic  adv_row;
    logic  emit;
    logic  halt;
    cond_t jcond;
    step_t jtgt;
  } ctl_t;

  // Control store
  function automatic ctl_t lpc_ucode(step_t pc);
    ctl_t w;
    w = '0;
    unique case (pc)
      S_ROW:   w.rd_row = 1'b1;
      S_LATCH: w.ld_row = 1'b1;
      S_CELL: begin
        w.begin_cell = 1'b1;
        w.jcond      = JC_CELL_CLR;
        w.jtgt       = S_NEXTC;
      end
      S_RD:    w.rd_row = 1'b0;
      S_CHK: begin
        w.chk_arm = 1'b1;
        w.jcond   = JC_ARM_GO;
        w.jtgt    = S_RD;
      end
      S_CMP:   w.cmp_best = 1'b1;
      S_NEXTC: begin
        w.adv_col = 1'b1;
        w.jcond   = JC_COL_MORE;
        w.jtgt    = S_CELL;
      end
      S_NEXTR: begin
        w.adv_row = 1'b1;
        w.jcond   = JC_ROW_MORE;
        w.jtgt    = S_ROW;
      end
      S_DONE: begin
        w.emit = 1'b1;
        w.halt = 1'b1;
      end
      default: w.halt = 1'b1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/largest_plus_cross_search.sv */
// ============================================================================
// largest_plus_cross_search
// Loads a square binary grid one cell per item, then searches it for the
// largest plus-shaped cross of set cells and reports its arm and center.
// ============================================================================
//
//  channel | ports                                     | handshake
//  --------+-------------------------------------------+---------------------
//  input   | in_cell_bit                               | start && !busy
//  result  | out_arm_length, out_center_row/_col       | out_valid, 1 cycle
//  config  | cfg_wdata (grid_dim)                      | cfg_we
//
//  Loading takes one cell per cycle while busy is low; the grid row is
//  written to the row RAM when its last cell arrives. The last cell starts
//  the search, and busy stays high through the result strobe. Each row reads
//  and latches its scan row; a clear cell is tested and skipped, and a set
//  cell walks its arm to the limit of 7, one arm distance per read and check
//  step through the row RAM's registered read. A done step emits the result.
//  Reset (synchronous) clears the counters, sets grid_dim to 15 and drops
//  busy. The receiver cannot stall; the result is valid for one cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module largest_plus_cross_search #(
  parameter int MAX_DIM = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_cell_bit,
  output logic                           out_valid,
  output logic [lpc_pkg::ARM_W-1:0]      out_arm_length,
  output logic [lpc_pkg::POS_W-1:0]      out_center_row,
  output logic [lpc_pkg::POS_W-1:0]      out_center_col,
  input  wire logic                      cfg_we,
  input  wire logic [lpc_pkg::DIM_W-1:0] cfg_wdata
);

  import lpc_pkg::*;

  localparam int IW = $clog2(MAX_DIM);      // row/column index
  localparam int DW = $clog2(MAX_DIM + 1);  // dimension value
  localparam int EW = IW + 4;               // index plus arm distance

  // Registers
  logic [DIM_W-1:0]   grid_dim_r, grid_dim_nxt;
  logic [IW-1:0]      ld_row_r, ld_row_nxt;
  logic [IW-1:0]      ld_col_r, ld_col_nxt;
  logic [MAX_DIM-1:0] row_buf_r, row_buf_nxt;
  logic               scan_r, scan_nxt;
  step_t              pc_r, pc_nxt;
  logic [IW-1:0]      sr_r, sr_nxt;
  logic [IW-1:0]      sc_r, sc_nxt;
  logic [ARM_W-1:0]   k_r, k_nxt;
  logic [ARM_W-1:0]   arm_r, arm_nxt;
  logic [MAX_DIM-1:0] cur_row_r, cur_row_nxt;
  logic [ARM_W-1:0]   best_arm_r, best_arm_nxt;
  logic [IW-1:0]      best_row_r, best_row_nxt;
  logic [IW-1:0]      best_col_r, best_col_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Dimension in use and its last index
  logic [DW-1:0] dim;
  logic [IW-1:0] d_last;

  always_comb begin
    if (grid_dim_r == '0) begin
      dim = DW'(1);
    end else if (32'(grid_dim_r) > MAX_DIM) begin
      dim = DW'(MAX_DIM);
    end else begin
      dim = DW'(grid_dim_r);
    end
    d_last = IW'(dim - DW'(1));
  end

  // Row RAM
  logic               ram_we;
  logic [MAX_DIM-1:0] ram_wdata;
  logic [IW-1:0]      ra_addr, rb_addr;
  logic [MAX_DIM-1:0] ra_data, rb_data;

  lpc_ram #(
    .WIDTH (MAX_DIM),
    .DEPTH (MAX_DIM)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ld_row_r),
    .wdata   (ram_wdata),
    .ra_addr (ra_addr),
    .ra_data (ra_data),
    .rb_addr (rb_addr),
    .rb_data (rb_data)
  );

  // Current control word
  ctl_t ctl;
  assign ctl = lpc_ucode(pc_r);

  // Arm geometry at distance k
  logic [EW-1:0] sr_e, sc_e, k_e, dim_e;
  logic [EW-1:0] up_e, dn_e, lt_e, rt_e;
  logic          up_ok, dn_ok, lt_ok, rt_ok, arm_ok;

  always_comb begin
    sr_e  = EW'(sr_r);
    sc_e  = EW'(sc_r);
    k_e   = EW'(k_r);
    dim_e = EW'(dim);
    up_e  = sr_e - k_e;
    dn_e  = sr_e + k_e;
    lt_e  = sc_e - k_e;
    rt_e  = sc_e + k_e;
    up_ok = (sr_e >= k_e) && ra_data[sc_r];
    dn_ok = (dn_e < dim_e) && rb_data[sc_r];
    lt_ok = (sc_e >= k_e) && cur_row_r[IW'(lt_e)];
    rt_ok = (rt_e < dim_e) && cur_row_r[IW'(rt_e)];
    arm_ok = up_ok && dn_ok && lt_ok && rt_ok;
  end

  assign ra_addr = ctl.rd_row ? sr_r : IW'(up_e);
  assign rb_addr = IW'(dn_e);

  // Jump decision
  logic col_more, row_more, jump;

  assign col_more = (sc_r != d_last);
  assign row_more = (sr_r != d_last);

  always_comb begin
    unique case (ctl.jcond)
      JC_NONE:     jump = 1'b0;
      JC_CELL_CLR: jump = !cur_row_r[sc_r];
      JC_ARM_GO:   jump = arm_ok && (k_r != ARM_MAX);
      JC_COL_MORE: jump = col_more;
      JC_ROW_MORE: jump = row_more;
      default:     jump = 1'b0;
    endcase
  end

  // Load path and sequencer datapath
  logic in_acc;
  assign in_acc = start && !busy;

  always_comb begin
    grid_dim_nxt  = grid_dim_r;
    ld_row_nxt    = ld_row_r;
    ld_col_nxt    = ld_col_r;
    row_buf_nxt   = row_buf_r;
    scan_nxt      = scan_r;
    pc_nxt        = pc_r;
    sr_nxt        = sr_r;
    sc_nxt        = sc_r;
    k_nxt         = k_r;
    arm_nxt       = arm_r;
    cur_row_nxt   = cur_row_r;
    best_arm_nxt  = best_arm_r;
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = row_buf_r;
    ram_wdata[ld_col_r] = in_cell_bit;

    // Take one cell; write the row when it closes, start the search on the last
    if (in_acc) begin
      row_buf_nxt[ld_col_r] = in_cell_bit;
      if (ld_col_r == d_last) begin
        ram_we     = 1'b1;
        ld_col_nxt = '0;
        if (ld_row_r == d_last) begin
          ld_row_nxt   = '0;
          scan_nxt     = 1'b1;
          pc_nxt       = S_ROW;
          sr_nxt       = '0;
          sc_nxt       = '0;
          best_arm_nxt = '0;
          best_row_nxt = '0;
          best_col_nxt = '0;
        end else begin
          ld_row_nxt = ld_row_r + IW'(1);
        end
      end else begin
        ld_col_nxt = ld_col_r + IW'(1);
      end
    end

    // Run one step of the search program
    if (scan_r) begin
      pc_nxt = jump ? ctl.jtgt : pc_r + STEP_W'(1);
      if (ctl.ld_row) begin
        cur_row_nxt = ra_data;
      end
      if (ctl.begin_cell) begin
        k_nxt   = ARM_W'(1);
        arm_nxt = '0;
      end
      if (ctl.chk_arm && arm_ok) begin
        arm_nxt = k_r;
        if (k_r != ARM_MAX) begin
          k_nxt = k_r + ARM_W'(1);
        end
      end
      if (ctl.cmp_best && (arm_r > best_arm_r)) begin
        best_arm_nxt = arm_r;
        best_row_nxt = sr_r;
        best_col_nxt = sc_r;
      end
      if (ctl.adv_col) begin
        sc_nxt = col_more ? sc_r + IW'(1) : '0;
      end
      if (ctl.adv_row && row_more) begin
        sr_nxt = sr_r + IW'(1);
      end
      if (ctl.emit) begin
        out_valid_nxt = 1'b1;
      end
      if (ctl.halt) begin
        scan_nxt = 1'b0;
      end
    end

    // Dimension write restarts the load
    if (cfg_we) begin
      grid_dim_nxt = cfg_wdata;
      ld_row_nxt   = '0;
      ld_col_nxt   = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_dim_r  <= DIM_W'(15);
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      scan_r      <= 1'b0;
      pc_r        <= S_ROW;
      out_valid_r <= 1'b0;
      best_arm_r  <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else begin
      grid_dim_r  <= grid_dim_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      scan_r      <= scan_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      best_arm_r  <= best_arm_nxt;
      best_row_r  <= best_row_nxt;
      best_col_r  <= best_col_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    row_buf_r <= row_buf_nxt;
    sr_r      <= sr_nxt;
    sc_r      <= sc_nxt;
    k_r       <= k_nxt;
    arm_r     <= arm_nxt;
    cur_row_r <= cur_row_nxt;
  end

  // Outputs; hold busy through the result strobe
  assign busy           = scan_r || out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_arm_length = best_arm_r;
  assign out_center_row = POS_W'(best_row_r);
  assign out_center_col = POS_W'(best_col_r);

endmodule

`default_nettype wire

/* rtl/core/lpc_ram.sv */
// ============================================================================
// lpc_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic      [WIDTH-1:0]         ra_data,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic      [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

/* rtl/core/lpc_chk.sv */
// ============================================================================
// lpc_chk
// Port-level checks of the plus-cross search, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lpc_chk (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      out_valid,
  input wire logic [lpc_pkg::ARM_W-1:0] out_arm_length,
  input wire logic [lpc_pkg::POS_W-1:0] out_center_row,
  input wire logic [lpc_pkg::POS_W-1:0] out_center_col
);

  // Reset drops busy and the result strobe
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("busy or result after reset");

  // A result only closes a search
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside a search");

  // The search ends with its result
  a_valid_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("search continues past its result");

  // Busy rises only on an accepted item
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy ##1 busy) |-> $past(start))
    else $error("search started without an item");

  // No cross reports center zero
  a_no_cross: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_arm_length == '0)) |->
      ((out_center_row == '0) && (out_center_col == '0)))
    else $error("center given without a cross");

endmodule

bind largest_plus_cross_search lpc_chk u_lpc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_arm_length (out_arm_length),
  .out_center_row (out_center_row),
  .out_center_col (out_center_col)
);

`default_nettype wire
